@@ rtl/rotation_matrix_to_quaternion_macros.svh @@
// assertion macros used by the rotation-matrix-to-quaternion checker
// expects signals clk and rst_n in the scope where a macro is used
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// same-cycle implication, disabled during reset
`define RMQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmq check failed");

// next-cycle implication, disabled during reset
`define RMQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmq check failed");

`endif

@@ rtl/rmq_pkg.sv @@
// shared types, defaults and width helpers for the matrix-to-quaternion block
// no dependencies
package rmq_pkg;

  localparam int RMQ_DATA_WIDTH = 16;
  localparam int RMQ_FRAC_BITS  = 14;
  localparam int RMQ_QDEPTH     = 4;

  // branch codes reported on case_used
  typedef enum logic [1:0] {
    CASE_TRACE = 2'd0,
    CASE_X     = 2'd1,
    CASE_Y     = 2'd2,
    CASE_Z     = 2'd3
  } rmq_case_t;

  // unsigned width that holds any positive radicand
  function automatic int rmq_rad_width(input int dw, input int fb);
    return ((dw > fb + 1) ? dw : fb + 1) + 2;
  endfunction

  // width of one queued item: case, bad flag, radicand, three numerators
  function automatic int rmq_item_width(input int dw, input int fb);
    return 3 + rmq_rad_width(dw, fb) + 3 * (dw + 1);
  endfunction

endpackage

@@ rtl/rmq_ifs.sv @@
// channel interfaces: matrix input, quaternion output, internal item queue
// depends on rmq_pkg
interface rmq_in_if #(parameter int DW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;
  modport source(output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                 input ready);
  modport sink(input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
               output ready);
endinterface

interface rmq_out_if #(parameter int DW = 16);
  import rmq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] qx, qy, qz, qw;
  rmq_case_t            case_used;
  logic                 bad_input;
  modport source(output valid, qx, qy, qz, qw, case_used, bad_input, input ready);
  modport sink(input valid, qx, qy, qz, qw, case_used, bad_input, output ready);
endinterface

interface rmq_item_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

@@ rtl/rmq_front.sv @@
// front end: picks the branch, forms the radicand and the three numerators
// depends on rmq_pkg and rmq_ifs
module rmq_front #(
  parameter int DATA_WIDTH = rmq_pkg::RMQ_DATA_WIDTH,
  parameter int FRAC_BITS  = rmq_pkg::RMQ_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  rmq_in_if.sink       in_ch,
  rmq_item_if.source   item
);
  import rmq_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int RW  = rmq_rad_width(DATA_WIDTH, FRAC_BITS);
  localparam int TW  = RW + 1;
  localparam int MW  = DW + 1;
  localparam int IW  = rmq_item_width(DATA_WIDTH, FRAC_BITS);
  localparam int EPS = ((1 << FRAC_BITS) + 50000) / 100000;
  localparam logic signed [TW-1:0] ONE_S = TW'(64'd1 << FRAC_BITS);
  localparam logic signed [TW-1:0] EPS_S = TW'(EPS);

  logic signed [TW-1:0] e11, e22, e33, t, rad;
  logic signed [MW-1:0] d32_23, d13_31, d21_12, s21_12, s13_31, s32_23;
  logic signed [MW-1:0] n0, n1, n2;
  rmq_case_t            cs;
  logic                 bad;
  logic [RW-1:0]        rfield;
  logic                 f_v_r;
  logic [IW-1:0]        f_data_r, f_data_nxt;
  logic                 f_ready;

  // element sums and differences
  always_comb begin
    e11    = TW'(in_ch.m11);
    e22    = TW'(in_ch.m22);
    e33    = TW'(in_ch.m33);
    t      = ONE_S + e11 + e22 + e33;
    d32_23 = MW'(in_ch.m32) - MW'(in_ch.m23);
    d13_31 = MW'(in_ch.m13) - MW'(in_ch.m31);
    d21_12 = MW'(in_ch.m21) - MW'(in_ch.m12);
    s21_12 = MW'(in_ch.m21) + MW'(in_ch.m12);
    s13_31 = MW'(in_ch.m13) + MW'(in_ch.m31);
    s32_23 = MW'(in_ch.m32) + MW'(in_ch.m23);
  end

  // branch choice; lanes hold the three small components in x,y,z,w order
  always_comb begin
    if (t > EPS_S) begin
      cs  = CASE_TRACE;
      rad = t;
      n0  = d32_23; n1 = d13_31; n2 = d21_12;
    end else if (in_ch.m11 > in_ch.m22 && in_ch.m11 > in_ch.m33) begin
      cs  = CASE_X;
      rad = ONE_S + e11 - e22 - e33;
      n0  = s21_12; n1 = s13_31; n2 = d32_23;
    end else if (in_ch.m22 > in_ch.m33) begin
      cs  = CASE_Y;
      rad = ONE_S + e22 - e11 - e33;
      n0  = s21_12; n1 = s32_23; n2 = d13_31;
    end else begin
      cs  = CASE_Z;
      rad = ONE_S + e33 - e11 - e22;
      n0  = s13_31; n1 = s32_23; n2 = d21_12;
    end
    bad        = rad[TW-1] || (rad == '0);
    rfield     = bad ? RW'(1) : rad[RW-1:0];
    f_data_nxt = {cs, bad, rfield, n2, n1, n0};
  end

  // output register toward the queue
  assign f_ready     = !f_v_r || item.ready;
  assign in_ch.ready = f_ready;
  assign item.valid  = f_v_r;
  assign item.data   = f_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (f_ready) begin
      f_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && f_ready) begin
      f_data_r <= f_data_nxt;
    end
  end

endmodule

@@ rtl/rmq_fifo.sv @@
// small queue between the front end and the arithmetic back end
// depends on rmq_pkg and rmq_ifs
module rmq_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = rmq_pkg::RMQ_QDEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  rmq_item_if.sink   wr,
  rmq_item_if.source rd
);
  import rmq_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push, pop;

  assign wr.ready = (cnt_r != CW'(DEPTH));
  assign rd.valid = (cnt_r != '0);
  assign rd.data  = mem_r[rp_r];
  assign push     = wr.valid && wr.ready;
  assign pop      = rd.valid && rd.ready;

  // pointer and fill count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr.data;
    end
  end

endmodule

@@ rtl/rmq_back.sv @@
// back end: pipelined square root, three pipelined dividers, saturation
// depends on rmq_pkg and rmq_ifs
module rmq_back #(
  parameter int DATA_WIDTH = rmq_pkg::RMQ_DATA_WIDTH,
  parameter int FRAC_BITS  = rmq_pkg::RMQ_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  rmq_item_if.sink   item,
  rmq_out_if.source  out_ch
);
  import rmq_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int RW  = rmq_rad_width(DATA_WIDTH, FRAC_BITS);
  localparam int IW  = rmq_item_width(DATA_WIDTH, FRAC_BITS);
  localparam int MW  = DW + 1;
  localparam int XW  = RW + FB;
  localparam int XE  = XW + (XW % 2);
  localparam int SQW = XE / 2;
  localparam int SW  = SQW + 1;
  localparam int NW  = MW + FB + 1;
  localparam int SCW = 6 + 3 * MW;
  localparam logic [NW-1:0] QMAX_U = NW'((64'd1 << (DW - 1)) - 64'd1);
  localparam logic [NW-1:0] QMIN_U = NW'(64'd1 << (DW - 1));
  localparam logic [DW-1:0] QMAX_B = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] QMIN_B = {1'b1, {(DW-1){1'b0}}};

  logic en;

  // item unpack
  logic [1:0]           i_cs;
  logic                 i_bad;
  logic [RW-1:0]        i_r;
  logic signed [MW-1:0] i_n [3];
  logic [MW-1:0]        i_mag [3];
  logic [2:0]           i_sgn;
  logic [SCW-1:0]       i_sc;

  always_comb begin
    {i_cs, i_bad, i_r, i_n[2], i_n[1], i_n[0]} = item.data;
    for (int j = 0; j < 3; j++) begin
      i_sgn[j] = i_n[j][MW-1];
      i_mag[j] = i_sgn[j] ? MW'(-i_n[j]) : MW'(i_n[j]);
    end
    i_sc = {i_cs, i_bad, i_sgn, i_mag[2], i_mag[1], i_mag[0]};
  end

  assign item.ready = en;

  // square root: one result bit per stage
  logic [XE-1:0]    sx_in   [SQW];
  logic [SQW+1:0]   srem_in [SQW];
  logic [SQW-1:0]   sroot_in[SQW];
  logic [SCW-1:0]   ssc_in  [SQW];
  logic             sv_in   [SQW];
  logic [XE-1:0]    sx_r    [SQW];
  logic [SQW+1:0]   srem_r  [SQW];
  logic [SQW-1:0]   sroot_r [SQW];
  logic [SCW-1:0]   ssc_r   [SQW];
  logic             sv_r    [SQW];

  assign sx_in[0]    = XE'(i_r) << FB;
  assign srem_in[0]  = '0;
  assign sroot_in[0] = '0;
  assign ssc_in[0]   = i_sc;
  assign sv_in[0]    = item.valid;

  for (genvar k = 0; k < SQW; k++) begin : g_sqrt
    logic [SQW+1:0] remsh, trial;
    logic           ge;
    if (k > 0) begin : g_link
      assign sx_in[k]    = sx_r[k-1];
      assign srem_in[k]  = srem_r[k-1];
      assign sroot_in[k] = sroot_r[k-1];
      assign ssc_in[k]   = ssc_r[k-1];
      assign sv_in[k]    = sv_r[k-1];
    end
    assign remsh = {srem_in[k][SQW-1:0], sx_in[k][XE-1 -: 2]};
    assign trial = {sroot_in[k], 2'b01};
    assign ge    = (remsh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k] <= 1'b0;
      end else if (en) begin
        sv_r[k] <= sv_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sx_r[k]    <= sx_in[k] << 2;
        srem_r[k]  <= ge ? remsh - trial : remsh;
        sroot_r[k] <= {sroot_in[k][SQW-2:0], ge};
        ssc_r[k]   <= ssc_in[k];
      end
    end
  end

  // divider entry: numerator mag * 2^FB + root rounds to nearest
  logic [SQW-1:0] root;
  logic [SW-1:0]  dvs0;
  logic [SQW-1:0] big0;
  logic [SQW:0]   root_inc;
  logic [MW-1:0]  sq_mag [3];

  always_comb begin
    root     = sroot_r[SQW-1];
    dvs0     = {root, 1'b0};
    root_inc = {1'b0, root} + (SQW+1)'(1);
    big0     = root_inc[SQW:1];
    {sq_mag[2], sq_mag[1], sq_mag[0]} = ssc_r[SQW-1][3*MW-1:0];
  end

  // restoring division: one quotient bit per stage, three lanes
  logic [SW-1:0]  ds_in  [NW];
  logic [SQW-1:0] dbig_in[NW];
  logic [SCW-1:0] dsc_in [NW];
  logic           dv_in  [NW];
  logic [SW-1:0]  ds_r   [NW];
  logic [SQW-1:0] dbig_r [NW];
  logic [SCW-1:0] dsc_r  [NW];
  logic           dv_r   [NW];
  logic [NW-1:0]  dn_in  [3][NW];
  logic [SW-1:0]  drem_in[3][NW];
  logic [NW-1:0]  dq_in  [3][NW];
  logic [NW-1:0]  dn_r   [3][NW];
  logic [SW-1:0]  drem_r [3][NW];
  logic [NW-1:0]  dq_r   [3][NW];

  assign ds_in[0]   = dvs0;
  assign dbig_in[0] = big0;
  assign dsc_in[0]  = ssc_r[SQW-1];
  assign dv_in[0]   = sv_r[SQW-1];

  for (genvar k = 0; k < NW; k++) begin : g_div
    if (k > 0) begin : g_link
      assign ds_in[k]   = ds_r[k-1];
      assign dbig_in[k] = dbig_r[k-1];
      assign dsc_in[k]  = dsc_r[k-1];
      assign dv_in[k]   = dv_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else if (en) begin
        dv_r[k] <= dv_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ds_r[k]   <= ds_in[k];
        dbig_r[k] <= dbig_in[k];
        dsc_r[k]  <= dsc_in[k];
      end
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [SW:0] remsh;
      logic        ge;
      if (k == 0) begin : g_first
        assign dn_in[j][0]   = {1'b0, sq_mag[j], {FB{1'b0}}} + NW'(root);
        assign drem_in[j][0] = '0;
        assign dq_in[j][0]   = '0;
      end else begin : g_link
        assign dn_in[j][k]   = dn_r[j][k-1];
        assign drem_in[j][k] = drem_r[j][k-1];
        assign dq_in[j][k]   = dq_r[j][k-1];
      end
      assign remsh = {drem_in[j][k], dn_in[j][k][NW-1]};
      assign ge    = (remsh >= {1'b0, ds_in[k]});

      always_ff @(posedge clk) begin
        if (en) begin
          dn_r[j][k]   <= dn_in[j][k] << 1;
          drem_r[j][k] <= ge ? SW'(remsh - {1'b0, ds_in[k]}) : remsh[SW-1:0];
          dq_r[j][k]   <= {dq_in[j][k][NW-2:0], ge};
        end
      end
    end
  end

  // saturation and placement of the large component
  logic [1:0]    f_cs;
  logic          f_bad;
  logic [2:0]    f_sgn;
  logic [DW-1:0] lane [3];
  logic [DW-1:0] f_big;
  logic [DW-1:0] q_nxt [4];
  logic [NW-1:0] qv;

  always_comb begin
    f_cs  = dsc_r[NW-1][SCW-1 -: 2];
    f_bad = dsc_r[NW-1][SCW-3];
    f_sgn = dsc_r[NW-1][SCW-4 -: 3];
    for (int j = 0; j < 3; j++) begin
      qv = dq_r[j][NW-1];
      if (f_sgn[j]) begin
        lane[j] = (qv > QMIN_U) ? QMIN_B : DW'(-qv);
      end else begin
        lane[j] = (qv > QMAX_U) ? QMAX_B : qv[DW-1:0];
      end
    end
    f_big = (NW'(dbig_r[NW-1]) > QMAX_U) ? QMAX_B : DW'(dbig_r[NW-1]);
    case (f_cs)
      CASE_TRACE: begin
        q_nxt[0] = lane[0]; q_nxt[1] = lane[1]; q_nxt[2] = lane[2]; q_nxt[3] = f_big;
      end
      CASE_X: begin
        q_nxt[0] = f_big; q_nxt[1] = lane[0]; q_nxt[2] = lane[1]; q_nxt[3] = lane[2];
      end
      CASE_Y: begin
        q_nxt[0] = lane[0]; q_nxt[1] = f_big; q_nxt[2] = lane[1]; q_nxt[3] = lane[2];
      end
      default: begin
        q_nxt[0] = lane[0]; q_nxt[1] = lane[1]; q_nxt[2] = f_big; q_nxt[3] = lane[2];
      end
    endcase
    if (f_bad) begin
      for (int j = 0; j < 4; j++) q_nxt[j] = '0;
    end
  end

  // output register; the whole pipe advances when it is free or taken
  logic          ov_r;
  logic [DW-1:0] oq_r [4];
  rmq_case_t     ocs_r;
  logic          obad_r;

  assign en = !ov_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= dv_r[NW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) oq_r[j] <= q_nxt[j];
      ocs_r  <= rmq_case_t'(f_cs);
      obad_r <= f_bad;
    end
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.qx        = oq_r[0];
  assign out_ch.qy        = oq_r[1];
  assign out_ch.qz        = oq_r[2];
  assign out_ch.qw        = oq_r[3];
  assign out_ch.case_used = ocs_r;
  assign out_ch.bad_input = obad_r;

endmodule

@@ rtl/rotation_matrix_to_quaternion.sv @@
// Rotation matrix (signed Qm.f) to unit quaternion, Shepperd's branch method.
// Input channel in_ch: nine matrix elements m11..m33, valid/ready handshake.
// Output channel out_ch: qx, qy, qz, qw, case_used (branch), bad_input flag.
// A transfer happens on any rising edge where valid and ready are both high.
// Throughput: one matrix per cycle, sustained, as long as out_ch is drained.
// From input transfer to out_ch.valid: front register, queue, root stages,
//   divider stages and output register; SQW = half the root operand width
//   (one root bit per stage), NW = DATA_WIDTH + FRAC_BITS + 2 (one quotient
//   bit per divider stage).
// The front end registers the branch choice and feeds a four-entry queue;
// the back end is a square-root pipeline followed by three parallel
// dividers and a saturating output register.
// When out_ch.ready is low with a result waiting, the back pipe holds, the
// queue fills, and in_ch.ready drops once the front register cannot drain.
// Reset (rst_n low, synchronous) empties every stage and the queue; there is
// no other state and no configuration.
// A non-positive radicand gives zero components with bad_input set.
// depends on rmq_pkg, rmq_ifs, rmq_front, rmq_fifo, rmq_back
module rotation_matrix_to_quaternion #(
  parameter int DATA_WIDTH = rmq_pkg::RMQ_DATA_WIDTH,
  parameter int FRAC_BITS  = rmq_pkg::RMQ_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  rmq_in_if.sink     in_ch,
  rmq_out_if.source  out_ch
);
  import rmq_pkg::*;

  localparam int IW = rmq_item_width(DATA_WIDTH, FRAC_BITS);

  rmq_item_if #(.W(IW)) front_q ();
  rmq_item_if #(.W(IW)) q_back ();

  // branch choice and operand forming
  rmq_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .item  (front_q)
  );

  // decoupling queue
  rmq_fifo #(.W(IW), .DEPTH(RMQ_QDEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (front_q),
    .rd    (q_back)
  );

  // root, division and output
  rmq_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (q_back),
    .out_ch (out_ch)
  );

endmodule

@@ rtl/rmq_checker.sv @@
// port-level checks for rotation_matrix_to_quaternion, bound to the top level
// depends on rmq_pkg and rotation_matrix_to_quaternion_macros.svh
`include "rotation_matrix_to_quaternion_macros.svh"

module rmq_checker #(
  parameter int DW = rmq_pkg::RMQ_DATA_WIDTH
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [DW-1:0] qx,
  input logic signed [DW-1:0] qy,
  input logic signed [DW-1:0] qz,
  input logic signed [DW-1:0] qw,
  input logic [1:0]           case_used,
  input logic                 bad_input
);
  import rmq_pkg::*;

  // a stalled result stays valid and keeps its qx and qw values
  `RMQ_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(qx) && $stable(qw))

  // a rejected radicand gives an all-zero quaternion
  `RMQ_ASSERT_NOW(a_bad_zero, out_valid && bad_input, qx == '0 && qy == '0 && qz == '0 && qw == '0)

  // the trace branch always has a positive radicand
  `RMQ_ASSERT_NOW(a_trace_ok, out_valid && case_used == CASE_TRACE, !bad_input)

  // the large component of the x branch is never negative
  `RMQ_ASSERT_NOW(a_x_big_pos, out_valid && case_used == CASE_X && !bad_input, !qx[DW-1])

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(.DW(DATA_WIDTH)) u_rmq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .qx        (out_ch.qx),
  .qy        (out_ch.qy),
  .qz        (out_ch.qz),
  .qw        (out_ch.qw),
  .case_used (out_ch.case_used),
  .bad_input (out_ch.bad_input)
);
